// File: hw/rtl/lds_pkg.sv
// lds_pkg: shared constants and types of the linear diophantine solver
// holds the data width, datapath widths, result status codes and sequencer states
// no dependencies
package lds_pkg;

  // width of the arithmetic the block models; coefficients use DataWidth-1 bits
  localparam int unsigned DataWidth = 32;

  localparam int unsigned CoefW = 31;  // coefficient and gcd field width
  localparam int unsigned RhsW  = 32;  // right-hand side field width
  localparam int unsigned SolW  = 64;  // solution field width
  localparam int unsigned MagW  = 32;  // divider operand width, holds |rhs|
  localparam int unsigned BzW   = 33;  // bezout coefficient and multiplier operand width
  localparam int unsigned ShW   = 5;   // divider alignment shift count

  localparam int unsigned RhsShift = RhsW - DataWidth;
  localparam logic [CoefW-1:0] CoefMask = CoefW'((64'd1 << (DataWidth - 1)) - 64'd1);

  typedef enum logic [1:0] {
    StSolved   = 2'd0,
    StNoSol    = 2'd1,
    StBothZero = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    SIdle,
    SEuTest,
    SAlign,
    SReduce,
    SEuMulX,
    SEuMulY,
    SEuUpdY,
    SScaleX,
    SScaleY,
    SScaleW,
    SOut
  } state_e;

  typedef enum logic {
    DivEuclid,
    DivRhs
  } divmode_e;

endpackage

// File: hw/rtl/linear_diophantine_solver_top.sv
// linear_diophantine_solver_top: solves a*x + b*y = c with the extended euclidean algorithm
// one shared shift-subtract divider and one shared 33x33 multiplier under a sequencer
// depends on lds_pkg
//
// usage:
//   input channel (in_valid_i / in_ready_o) carries one transaction of coef_a_i, coef_b_i
//   and rhs_i; output channel (out_valid_o / out_ready_i) returns one transaction of
//   sol_x_o, sol_y_o, divisor_o and status_o for each input transaction, in order.
//   the block works on one transaction at a time: in_ready_o is high only while idle.
// sequence:
//   both coefficients zero: out_valid_o rises in the cycle after acceptance.
//   otherwise each euclid step runs a zero test, then alignment shifts up and restoring
//   shift-subtract back down over the bit-length gap k between the two remainders, then
//   the bezout updates on the shared multiplier; then one more division of |c| by the gcd
//   (the zero test included) and scaling on the shared multiplier when a solution exists.
//   the block takes a new transaction only after the last result is taken, since it
//   passes through idle between transactions.
// reset:
//   rst_ni clears the sequencer to idle; no result is pending after reset.
// stall:
//   a finished result holds on the outputs until out_ready_i takes it; no new input
//   transaction is accepted meanwhile.
module linear_diophantine_solver_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [lds_pkg::CoefW-1:0]        coef_a_i,
  input  logic [lds_pkg::CoefW-1:0]        coef_b_i,
  input  logic signed [lds_pkg::RhsW-1:0]  rhs_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [lds_pkg::SolW-1:0]  sol_x_o,
  output logic signed [lds_pkg::SolW-1:0]  sol_y_o,
  output logic [lds_pkg::CoefW-1:0]        divisor_o,
  output lds_pkg::status_e                 status_o
);
  import lds_pkg::*;

  // sequencer
  state_e state_q, state_d;

  // euclid remainders and bezout coefficients (old and current column)
  logic [CoefW-1:0]      r0_q, r0_d, r1_q, r1_d;
  logic signed [BzW-1:0] x0_q, x0_d, x1_q, x1_d;
  logic signed [BzW-1:0] y0_q, y0_d, y1_q, y1_d;
  logic [RhsW-1:0]       rhs_q, rhs_d;

  // shared divider: partial remainder, aligned divisor, shift count, quotient
  logic [MagW-1:0] num_q, num_d;
  logic [MagW-1:0] den_q, den_d;
  logic [ShW-1:0]  sh_q, sh_d;
  logic [MagW-1:0] quo_q, quo_d;
  divmode_e        mode_q, mode_d;
  logic            neg_q, neg_d;

  // shared multiplier, product registered
  logic signed [BzW-1:0]     mul_a, mul_b;
  logic signed [2*BzW-1:0]   mul_p;
  logic signed [SolW-1:0]    prod_q;

  // result registers
  logic signed [SolW-1:0] sol_x_q, sol_x_d, sol_y_q, sol_y_d;
  logic [CoefW-1:0]       div_q, div_d;
  status_e                status_q, status_d;

  // input conditioning: coefficients masked, rhs sign-extended from DataWidth bits
  logic [CoefW-1:0] coef_a_m, coef_b_m;
  logic [RhsW-1:0]  rhs_ext;
  logic             in_fire;

  assign coef_a_m = coef_a_i & CoefMask;
  assign coef_b_m = coef_b_i & CoefMask;
  assign rhs_ext  = RhsW'((rhs_i <<< RhsShift) >>> RhsShift);
  assign in_fire  = in_valid_i && in_ready_o;

  // divider step logic
  logic            align_ok, sub_ok, last_bit;
  logic [MagW-1:0] num_sub, rem_after, quo_next, rhs_abs;

  assign align_ok  = {den_q, 1'b0} <= {1'b0, num_q};
  assign sub_ok    = num_q >= den_q;
  assign num_sub   = num_q - den_q;
  assign rem_after = sub_ok ? num_sub : num_q;
  assign quo_next  = {quo_q[MagW-2:0], sub_ok};
  assign last_bit  = (sh_q == '0);
  assign rhs_abs   = rhs_q[RhsW-1] ? (~rhs_q + 1'b1) : rhs_q;

  // quotient as a signed operand, and the scale factor c/g with its sign
  logic signed [BzW-1:0] quo_s, k_s;

  assign quo_s = signed'({1'b0, quo_q});
  assign k_s   = neg_q ? -quo_s : quo_s;

  assign mul_p = mul_a * mul_b;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: begin
        if (in_fire) begin
          state_d = ((coef_a_m == '0) && (coef_b_m == '0)) ? SOut : SEuTest;
        end
      end
      SEuTest: state_d = SAlign;
      SAlign: begin
        if (!align_ok) begin
          state_d = SReduce;
        end
      end
      SReduce: begin
        if (last_bit) begin
          if (mode_q == DivEuclid) begin
            state_d = SEuMulX;
          end else begin
            state_d = (rem_after != '0) ? SOut : SScaleX;
          end
        end
      end
      SEuMulX: state_d = SEuMulY;
      SEuMulY: state_d = SEuUpdY;
      SEuUpdY: state_d = SEuTest;
      SScaleX: state_d = SScaleY;
      SScaleY: state_d = SScaleW;
      SScaleW: state_d = SOut;
      SOut: begin
        if (out_ready_i) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  // handshake outputs and multiplier operand selection
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    mul_a       = quo_s;
    mul_b       = x1_q;
    unique case (state_q)
      SIdle:   in_ready_o  = 1'b1;
      SOut:    out_valid_o = 1'b1;
      SEuMulX: begin
        mul_a = quo_s;
        mul_b = x1_q;
      end
      SEuMulY: begin
        mul_a = quo_s;
        mul_b = y1_q;
      end
      SScaleX: begin
        mul_a = x0_q;
        mul_b = k_s;
      end
      SScaleY: begin
        mul_a = y0_q;
        mul_b = k_s;
      end
      default: begin
        mul_a = quo_s;
        mul_b = x1_q;
      end
    endcase
  end

  // datapath
  always_comb begin
    r0_d     = r0_q;
    r1_d     = r1_q;
    x0_d     = x0_q;
    x1_d     = x1_q;
    y0_d     = y0_q;
    y1_d     = y1_q;
    rhs_d    = rhs_q;
    num_d    = num_q;
    den_d    = den_q;
    sh_d     = sh_q;
    quo_d    = quo_q;
    mode_d   = mode_q;
    neg_d    = neg_q;
    sol_x_d  = sol_x_q;
    sol_y_d  = sol_y_q;
    div_d    = div_q;
    status_d = status_q;
    case (state_q)
      SIdle: begin
        if (in_fire) begin
          r0_d     = coef_a_m;
          r1_d     = coef_b_m;
          x0_d     = BzW'(1);
          x1_d     = '0;
          y0_d     = '0;
          y1_d     = BzW'(1);
          rhs_d    = rhs_ext;
          sol_x_d  = '0;
          sol_y_d  = '0;
          div_d    = '0;
          status_d = StBothZero;
        end
      end
      SEuTest: begin
        sh_d  = '0;
        quo_d = '0;
        if (r1_q == '0) begin
          // gcd found: divide |c| by it
          num_d  = rhs_abs;
          den_d  = MagW'(r0_q);
          mode_d = DivRhs;
          neg_d  = rhs_q[RhsW-1];
          div_d  = r0_q;
        end else begin
          num_d  = MagW'(r0_q);
          den_d  = MagW'(r1_q);
          mode_d = DivEuclid;
        end
      end
      SAlign: begin
        if (align_ok) begin
          den_d = {den_q[MagW-2:0], 1'b0};
          sh_d  = sh_q + 1'b1;
        end
      end
      SReduce: begin
        num_d = rem_after;
        quo_d = quo_next;
        if (!last_bit) begin
          den_d = {1'b0, den_q[MagW-1:1]};
          sh_d  = sh_q - 1'b1;
        end else if ((mode_q == DivRhs) && (rem_after != '0)) begin
          sol_x_d  = '0;
          sol_y_d  = '0;
          status_d = StNoSol;
        end
      end
      SEuMulY: begin
        x0_d = x1_q;
        x1_d = x0_q - signed'(prod_q[BzW-1:0]);
      end
      SEuUpdY: begin
        y0_d = y1_q;
        y1_d = y0_q - signed'(prod_q[BzW-1:0]);
        r0_d = r1_q;
        r1_d = num_q[CoefW-1:0];
      end
      SScaleY: sol_x_d = prod_q;
      SScaleW: begin
        sol_y_d  = prod_q;
        status_d = StSolved;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r0_q     <= r0_d;
    r1_q     <= r1_d;
    x0_q     <= x0_d;
    x1_q     <= x1_d;
    y0_q     <= y0_d;
    y1_q     <= y1_d;
    rhs_q    <= rhs_d;
    num_q    <= num_d;
    den_q    <= den_d;
    sh_q     <= sh_d;
    quo_q    <= quo_d;
    mode_q   <= mode_d;
    neg_q    <= neg_d;
    prod_q   <= mul_p[SolW-1:0];
    sol_x_q  <= sol_x_d;
    sol_y_q  <= sol_y_d;
    div_q    <= div_d;
    status_q <= status_d;
  end

  assign sol_x_o   = sol_x_q;
  assign sol_y_o   = sol_y_q;
  assign divisor_o = div_q;
  assign status_o  = status_q;

  // checks
  a_ready_valid_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted a second transaction while busy");

  a_both_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StBothZero) |->
      (divisor_o == '0) && (sol_x_o == '0) && (sol_y_o == '0))
    else $error("both-zero result carries nonzero fields");

  a_nosol_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StNoSol) |->
      (divisor_o != '0) && (sol_x_o == '0) && (sol_y_o == '0))
    else $error("no-solution result malformed");

  a_solved_gcd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StSolved) |-> (divisor_o != '0))
    else $error("solved result with zero gcd");

endmodule
